// ----- rtl/pfe_pkg.sv -----
// Package of the printf format engine: ASCII codes, microcode word types,
// the microcode program and small lookup functions.
// Depends on nothing; the top level and pfe_rsp_stage use it.
package pfe_pkg;

   localparam logic [7:0] CH_PCT      = 8'h25;
   localparam logic [7:0] CH_U        = 8'h75;
   localparam logic [7:0] CH_D        = 8'h64;
   localparam logic [7:0] CH_C        = 8'h63;
   localparam logic [7:0] CH_X        = 8'h78;
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_LF       = 8'h0A;
   localparam logic [7:0] CH_ZERO     = 8'h30;
   localparam logic [7:0] CH_MINUS    = 8'h2D;
   localparam logic [7:0] HEX_ALPHA   = 8'h37;

   typedef logic [4:0] pc_type;

   localparam pc_type PC_IDLE  = 5'd0;
   localparam pc_type PC_UNK   = 5'd1;
   localparam pc_type PC_PLAIN = 5'd2;
   localparam pc_type PC_PCT   = 5'd4;
   localparam pc_type PC_CHR   = 5'd5;
   localparam pc_type PC_HEX   = 5'd6;
   localparam pc_type PC_MINUS = 5'd12;
   localparam pc_type PC_DEC   = 5'd13;
   localparam pc_type PC_LEN   = 5'd23;

   typedef enum logic [1:0] {
      OP_IDLE,
      OP_EMIT,
      OP_SUB,
      OP_DIGIT
   } op_type;

   typedef enum logic [3:0] {
      SRC_CH,
      SRC_CR,
      SRC_PCT,
      SRC_ARG_LO,
      SRC_ZERO,
      SRC_LX,
      SRC_HEX,
      SRC_MINUS,
      SRC_DIGIT
   } src_type;

   typedef enum logic [1:0] {
      LAST_NO,
      LAST_YES,
      LAST_NOT_LF
   } last_type;

   typedef struct packed {
      op_type     op;
      src_type    src;
      last_type   last_sel;
      logic [2:0] idx;
   } ucode_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] data;
      logic       last;
   } emit_type;

   function automatic ucode_type pfe_ucode(input pc_type pc);
      ucode_type w;
      w = '{op: OP_IDLE, src: SRC_CH, last_sel: LAST_NO, idx: 3'd0};
      unique case (pc)
         5'd1:  w = '{op: OP_EMIT,  src: SRC_PCT,    last_sel: LAST_NO,     idx: 3'd0};
         5'd2:  w = '{op: OP_EMIT,  src: SRC_CH,     last_sel: LAST_NOT_LF, idx: 3'd0};
         5'd3:  w = '{op: OP_EMIT,  src: SRC_CR,     last_sel: LAST_YES,    idx: 3'd0};
         5'd4:  w = '{op: OP_EMIT,  src: SRC_PCT,    last_sel: LAST_YES,    idx: 3'd0};
         5'd5:  w = '{op: OP_EMIT,  src: SRC_ARG_LO, last_sel: LAST_YES,    idx: 3'd0};
         5'd6:  w = '{op: OP_EMIT,  src: SRC_ZERO,   last_sel: LAST_NO,     idx: 3'd0};
         5'd7:  w = '{op: OP_EMIT,  src: SRC_LX,     last_sel: LAST_NO,     idx: 3'd0};
         5'd8:  w = '{op: OP_EMIT,  src: SRC_HEX,    last_sel: LAST_NO,     idx: 3'd3};
         5'd9:  w = '{op: OP_EMIT,  src: SRC_HEX,    last_sel: LAST_NO,     idx: 3'd2};
         5'd10: w = '{op: OP_EMIT,  src: SRC_HEX,    last_sel: LAST_NO,     idx: 3'd1};
         5'd11: w = '{op: OP_EMIT,  src: SRC_HEX,    last_sel: LAST_YES,    idx: 3'd0};
         5'd12: w = '{op: OP_EMIT,  src: SRC_MINUS,  last_sel: LAST_NO,     idx: 3'd0};
         5'd13: w = '{op: OP_SUB,   src: SRC_DIGIT,  last_sel: LAST_NO,     idx: 3'd4};
         5'd14: w = '{op: OP_DIGIT, src: SRC_DIGIT,  last_sel: LAST_NO,     idx: 3'd4};
         5'd15: w = '{op: OP_SUB,   src: SRC_DIGIT,  last_sel: LAST_NO,     idx: 3'd3};
         5'd16: w = '{op: OP_DIGIT, src: SRC_DIGIT,  last_sel: LAST_NO,     idx: 3'd3};
         5'd17: w = '{op: OP_SUB,   src: SRC_DIGIT,  last_sel: LAST_NO,     idx: 3'd2};
         5'd18: w = '{op: OP_DIGIT, src: SRC_DIGIT,  last_sel: LAST_NO,     idx: 3'd2};
         5'd19: w = '{op: OP_SUB,   src: SRC_DIGIT,  last_sel: LAST_NO,     idx: 3'd1};
         5'd20: w = '{op: OP_DIGIT, src: SRC_DIGIT,  last_sel: LAST_NO,     idx: 3'd1};
         5'd21: w = '{op: OP_SUB,   src: SRC_DIGIT,  last_sel: LAST_NO,     idx: 3'd0};
         5'd22: w = '{op: OP_DIGIT, src: SRC_DIGIT,  last_sel: LAST_YES,    idx: 3'd0};
         default: w = '{op: OP_IDLE, src: SRC_CH, last_sel: LAST_NO, idx: 3'd0};
      endcase
      return w;
   endfunction

   function automatic logic [15:0] pfe_pow10(input logic [2:0] idx);
      logic [15:0] p;
      unique case (idx)
         3'd1:    p = 16'd10;
         3'd2:    p = 16'd100;
         3'd3:    p = 16'd1000;
         3'd4:    p = 16'd10000;
         default: p = 16'd1;
      endcase
      return p;
   endfunction

   function automatic logic [7:0] pfe_hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib >= 4'd10) begin
         c = {4'd0, nib} + HEX_ALPHA;
      end else begin
         c = {4'd0, nib} + CH_ZERO;
      end
      return c;
   endfunction

endpackage

// ----- rtl/pfe_channels.sv -----
// Valid/ready channel interfaces of the printf format engine: the request
// channel with one format character and the result channel with one byte.
// Depends on nothing.
interface pfe_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  fmt_char;
   logic [15:0] arg_value;
   logic        string_start;

   modport source (output valid, output fmt_char, output arg_value,
                   output string_start, input ready);
   modport sink   (input valid, input fmt_char, input arg_value,
                   input string_start, output ready);
endinterface

interface pfe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_of_run;

   modport source (output valid, output out_byte, output last_of_run, input ready);
   modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ----- rtl/printf_format_engine_unit.sv -----
// Top level of the printf format engine: microcode sequencer and datapath.
// Depends on pfe_pkg, pfe_req_if, pfe_rsp_if and pfe_rsp_stage.
// An accepted request is first registered in the step counter and operand
// registers; its first byte is then registered in the output register, and a
// step that emits a byte stalls while the output register cannot take it. The
// decimal digits of %u and %d come from one compare-and-subtract step per
// cycle against the powers of ten. A request is taken only when idle.
// Reset is synchronous and clears the step counter, the pending-percent flag
// and the output register.
module printf_format_engine_unit (
   input  logic    clock,
   input  logic    reset,
   pfe_req_if.sink   req_ch,
   pfe_rsp_if.source rsp_ch
);

   pfe_pkg::pc_type    pc_ff, pc_in;
   logic               pend_ff, pend_in;
   logic [7:0]         ch_ff, ch_in;
   logic [15:0]        val_ff, val_in;
   logic [3:0]         digit_ff, digit_in;
   logic               started_ff, started_in;
   pfe_pkg::ucode_type uc;
   pfe_pkg::emit_type  emit;
   logic               emit_ready;
   logic               pend_eff;
   logic               do_emit;
   logic [15:0]        pow;
   logic [3:0]         nib;
   logic [7:0]         sel_byte;
   logic               sel_last;

   assign uc  = pfe_pkg::pfe_ucode(pc_ff);
   assign pow = pfe_pkg::pfe_pow10(uc.idx);

   assign req_ch.ready = (uc.op == pfe_pkg::OP_IDLE);
   assign pend_eff     = pend_ff && !req_ch.string_start;

   always_comb begin
      unique case (uc.idx[1:0])
         2'd3:    nib = val_ff[15:12];
         2'd2:    nib = val_ff[11:8];
         2'd1:    nib = val_ff[7:4];
         default: nib = val_ff[3:0];
      endcase
   end

   always_comb begin
      unique case (uc.src)
         pfe_pkg::SRC_CH:     sel_byte = ch_ff;
         pfe_pkg::SRC_CR:     sel_byte = pfe_pkg::CH_CR;
         pfe_pkg::SRC_PCT:    sel_byte = pfe_pkg::CH_PCT;
         pfe_pkg::SRC_ARG_LO: sel_byte = val_ff[7:0];
         pfe_pkg::SRC_ZERO:   sel_byte = pfe_pkg::CH_ZERO;
         pfe_pkg::SRC_LX:     sel_byte = pfe_pkg::CH_X;
         pfe_pkg::SRC_HEX:    sel_byte = pfe_pkg::pfe_hex_char(nib);
         pfe_pkg::SRC_MINUS:  sel_byte = pfe_pkg::CH_MINUS;
         pfe_pkg::SRC_DIGIT:  sel_byte = {4'd0, digit_ff} + pfe_pkg::CH_ZERO;
         default:             sel_byte = ch_ff;
      endcase
      unique case (uc.last_sel)
         pfe_pkg::LAST_NO:     sel_last = 1'b0;
         pfe_pkg::LAST_YES:    sel_last = 1'b1;
         pfe_pkg::LAST_NOT_LF: sel_last = (ch_ff != pfe_pkg::CH_LF);
         default:              sel_last = 1'b1;
      endcase
   end

   assign do_emit = (uc.op == pfe_pkg::OP_EMIT) ||
                    ((uc.op == pfe_pkg::OP_DIGIT) &&
                     ((digit_ff != 4'd0) || started_ff || sel_last));

   assign emit = '{valid: do_emit, data: sel_byte, last: sel_last};

   always_comb begin
      pc_in      = pc_ff;
      pend_in    = pend_ff;
      ch_in      = ch_ff;
      val_in     = val_ff;
      digit_in   = digit_ff;
      started_in = started_ff;
      unique case (uc.op)
         pfe_pkg::OP_IDLE: begin
            if (req_ch.valid) begin
               ch_in      = req_ch.fmt_char;
               val_in     = req_ch.arg_value;
               digit_in   = 4'd0;
               started_in = 1'b0;
               pend_in    = 1'b0;
               if (!pend_eff) begin
                  if (req_ch.fmt_char == pfe_pkg::CH_PCT) begin
                     pend_in = 1'b1;
                  end else begin
                     pc_in = pfe_pkg::PC_PLAIN;
                  end
               end else begin
                  priority if (req_ch.fmt_char == pfe_pkg::CH_U) begin
                     pc_in = pfe_pkg::PC_DEC;
                  end else if (req_ch.fmt_char == pfe_pkg::CH_D) begin
                     if (req_ch.arg_value[15]) begin
                        val_in = 16'(17'h10000 - {1'b0, req_ch.arg_value});
                        pc_in  = pfe_pkg::PC_MINUS;
                     end else begin
                        pc_in = pfe_pkg::PC_DEC;
                     end
                  end else if (req_ch.fmt_char == pfe_pkg::CH_C) begin
                     pc_in = pfe_pkg::PC_CHR;
                  end else if (req_ch.fmt_char == pfe_pkg::CH_X) begin
                     pc_in = pfe_pkg::PC_HEX;
                  end else if (req_ch.fmt_char == pfe_pkg::CH_PCT) begin
                     pc_in = pfe_pkg::PC_PCT;
                  end else begin
                     pc_in = pfe_pkg::PC_UNK;
                  end
               end
            end
         end
         pfe_pkg::OP_SUB: begin
            if (val_ff >= pow) begin
               val_in   = val_ff - pow;
               digit_in = digit_ff + 4'd1;
            end else begin
               pc_in = pfe_pkg::pc_type'(pc_ff + 5'd1);
            end
         end
         pfe_pkg::OP_EMIT, pfe_pkg::OP_DIGIT: begin
            if (!do_emit) begin
               pc_in = pfe_pkg::pc_type'(pc_ff + 5'd1);
            end else if (emit_ready) begin
               pc_in = sel_last ? pfe_pkg::PC_IDLE : pfe_pkg::pc_type'(pc_ff + 5'd1);
               if (uc.op == pfe_pkg::OP_DIGIT) begin
                  started_in = 1'b1;
                  digit_in   = 4'd0;
               end
            end
         end
         default: pc_in = pfe_pkg::PC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff   <= pfe_pkg::PC_IDLE;
         pend_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         pend_ff <= pend_in;
      end
      ch_ff      <= ch_in;
      val_ff     <= val_in;
      digit_ff   <= digit_in;
      started_ff <= started_in;
   end

   pfe_rsp_stage u_rsp_stage (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .emit_ready (emit_ready),
      .rsp_ch     (rsp_ch)
   );

   a_pc_in_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff < pfe_pkg::PC_LEN)
      else $error("step counter left the program");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && emit_ready && emit.last) |=> (pc_ff == pfe_pkg::PC_IDLE))
      else $error("sequencer did not return to idle after the final byte");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      (uc.op == pfe_pkg::OP_DIGIT) |-> (digit_ff <= 4'd9))
      else $error("decimal digit out of range");

   a_no_accept_while_emitting: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.valid && req_ch.ready && emit.valid))
      else $error("request accepted while a byte is being emitted");

   a_sub_bound: assert property (@(posedge clock) disable iff (reset)
      ((uc.op == pfe_pkg::OP_SUB) && (uc.idx != 3'd4)) |-> (val_ff < 16'(pow * 16'd10)))
      else $error("remainder exceeds the current decimal position");

endmodule

// ----- rtl/pfe_rsp_stage.sv -----
// Output register of the printf format engine: holds one emitted byte until
// the result channel takes it. Depends on pfe_pkg and pfe_rsp_if.
module pfe_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  pfe_pkg::emit_type emit,
   output logic              emit_ready,
   pfe_rsp_if.source         rsp_ch
);

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;

   assign emit_ready = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (emit.valid && emit_ready) begin
         valid_in = 1'b1;
         data_in  = emit.data;
         last_in  = emit.last;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.out_byte    = data_ff;
   assign rsp_ch.last_of_run = last_ff;

endmodule
